@@ hw/rtl/mbap_stream_deframer_assert.svh @@
// Assertion macros used by the checker file of the MBAP deframer.
`ifndef MBAP_STREAM_DEFRAMER_ASSERT_SVH
`define MBAP_STREAM_DEFRAMER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define MBAP_SD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define MBAP_SD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mbap_sd_pkg.sv @@
package mbap_sd_pkg;

   localparam int MAX_FRAME_DEF = 260;
   localparam int HDR_LEN       = 6;
   localparam int MIN_FRAME     = 8;
   localparam int MIN_LEN       = MIN_FRAME - HDR_LEN;

   // Configuration register indexes.
   localparam logic CSR_SERVER_MODE  = 1'b0;
   localparam logic CSR_EXPECTED_TID = 1'b1;

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_RESYNC = 3'd1,
      ST_SHORT  = 3'd2,
      ST_PROTO  = 3'd3,
      ST_TID    = 3'd4
   } status_type;

   typedef struct packed {
      logic        write_en;
      logic        index;
      logic [15:0] wdata;
   } csr_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } in_item_type;

   typedef struct packed {
      logic        valid;
      logic [7:0]  pdu_byte;
      logic        last_byte;
      status_type  status;
      logic [15:0] frame_tid;
   } rsp_item_type;

endpackage

@@ hw/rtl/mbap_sd_in_reg.sv @@
module mbap_sd_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [7:0]               req_rx_byte,
   input  logic                     advance,
   output mbap_sd_pkg::in_item_type item
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   // The register takes a new item when it is empty or its item moves on.
   assign load     = !valid_ff || advance;
   assign valid_in = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         data_ff <= req_rx_byte;
      end
   end

   assign item.valid = valid_ff;
   assign item.data  = data_ff;

endmodule

@@ hw/rtl/mbap_sd_parse.sv @@
module mbap_sd_parse #(
   parameter int MAX_FRAME = mbap_sd_pkg::MAX_FRAME_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mbap_sd_pkg::csr_type      csr,
   input  mbap_sd_pkg::in_item_type  item,
   input  logic                      advance,
   output mbap_sd_pkg::rsp_item_type result
);

   localparam int POS_W = $clog2(MAX_FRAME);
   localparam logic [POS_W-1:0] HDR_POS  = POS_W'(mbap_sd_pkg::HDR_LEN);
   localparam logic [POS_W-1:0] HDR_LAST = POS_W'(mbap_sd_pkg::HDR_LEN - 1);
   localparam logic [POS_W:0]   BODY_OFS = (POS_W+1)'(mbap_sd_pkg::HDR_LEN - 1);

   logic [7:0]       hdr_ff [5];
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;
   logic [POS_W-1:0] flen_ff;
   logic [POS_W-1:0] flen_in;
   logic             skip_ff;
   logic             skip_in;
   logic             server_mode_ff;
   logic [15:0]      expected_tid_ff;

   logic             fire;
   logic             emit;
   logic [15:0]      len;
   logic [15:0]      proto;
   logic [15:0]      tid;
   logic             bogus;
   logic             last;
   mbap_sd_pkg::status_type st;

   assign fire  = item.valid && advance;
   assign len   = {hdr_ff[4], item.data};
   assign proto = {hdr_ff[2], hdr_ff[3]};
   assign tid   = {hdr_ff[0], hdr_ff[1]};
   assign bogus = ({1'b0, len} + 17'(mbap_sd_pkg::HDR_LEN)) > 17'(MAX_FRAME);
   assign last  = ({1'b0, pos_ff} - BODY_OFS) >= {1'b0, flen_ff};

   always_comb begin
      pos_in  = pos_ff + 1'b1;
      flen_in = flen_ff;
      skip_in = skip_ff;
      emit    = 1'b0;
      st      = mbap_sd_pkg::ST_DATA;
      if (pos_ff < HDR_POS) begin
         if (pos_ff == HDR_LAST) begin
            if (bogus) begin
               pos_in  = '0;
               skip_in = 1'b0;
               emit    = 1'b1;
               st      = mbap_sd_pkg::ST_RESYNC;
            end else begin
               // The length is known to fit the position counter here.
               flen_in = len[POS_W-1:0];
               if (len < 16'(mbap_sd_pkg::MIN_LEN)) begin
                  st = mbap_sd_pkg::ST_SHORT;
               end else if (proto != 16'd0) begin
                  st = mbap_sd_pkg::ST_PROTO;
               end else if (!server_mode_ff && tid != expected_tid_ff) begin
                  st = mbap_sd_pkg::ST_TID;
               end
               skip_in = (st != mbap_sd_pkg::ST_DATA);
               emit    = (st != mbap_sd_pkg::ST_DATA);
               if (emit && len == 16'd0) begin
                  pos_in  = '0;
                  skip_in = 1'b0;
               end
            end
         end
      end else begin
         if (last) begin
            pos_in  = '0;
            skip_in = 1'b0;
         end
         emit = !skip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         skip_ff         <= 1'b0;
         server_mode_ff  <= 1'b0;
         expected_tid_ff <= '0;
      end else begin
         if (fire) begin
            pos_ff  <= pos_in;
            skip_ff <= skip_in;
         end
         if (csr.write_en) begin
            case (csr.index)
               mbap_sd_pkg::CSR_SERVER_MODE:  server_mode_ff  <= csr.wdata[0];
               mbap_sd_pkg::CSR_EXPECTED_TID: expected_tid_ff <= csr.wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         flen_ff <= flen_in;
         if (pos_ff < HDR_LAST) begin
            hdr_ff[pos_ff[2:0]] <= item.data;
         end
      end
   end

   // Bytes 0 and 1 of the header are in place whenever a result is due.
   assign result.valid     = fire && emit;
   assign result.pdu_byte  = (st == mbap_sd_pkg::ST_DATA) ? item.data : 8'd0;
   assign result.last_byte = (pos_ff >= HDR_POS) && last;
   assign result.status    = st;
   assign result.frame_tid = tid;

endmodule

@@ hw/rtl/mbap_sd_out_reg.sv @@
module mbap_sd_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  mbap_sd_pkg::rsp_item_type result,
   input  logic                      rsp_stall,
   output logic                      advance,
   output mbap_sd_pkg::rsp_item_type rsp
);

   logic                      valid_ff;
   logic                      valid_in;
   mbap_sd_pkg::rsp_item_type data_ff;

   // A held item blocks the pipe; otherwise the register reloads every cycle.
   assign advance  = !(valid_ff && rsp_stall);
   assign valid_in = advance ? result.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         data_ff <= result;
      end
   end

   always_comb begin
      rsp       = data_ff;
      rsp.valid = valid_ff;
   end

endmodule

@@ hw/rtl/mbap_stream_deframer.sv @@
// MBAP stream deframer.
// The req_ channel carries one byte of a Modbus TCP stream per item. The six
// header bytes are collected; header bytes and skipped body bytes give no
// rsp_ item. A header that fails a check gives one rsp_ item with an error
// status and a zero byte; an accepted frame gives one rsp_ item per unit and
// PDU byte, with rsp_last_byte set on its final byte.
// The csr_ port writes server_mode (index 0) and expected_tid (index 1). The
// user must see that it is written while the block is idle; the block does not
// enforce this. A write bears on headers that complete later.
// An accepted byte waits in the input register and passes through the parse
// logic into the result register, which drives rsp_valid.
// Throughput is one byte per cycle while no result is stalled, set by the
// single pass through the parse logic that updates the frame position counter.
// Synchronous reset clears the position counter, the skip flag, both valid
// flags and the configuration registers to zero.
// While rsp_stall holds a waiting result, that result stays put and req_stall
// rises as soon as the input register is full; nothing is lost or repeated.
module mbap_stream_deframer #(
   parameter int MAX_FRAME = mbap_sd_pkg::MAX_FRAME_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_pdu_byte,
   output logic        rsp_last_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_frame_tid,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   mbap_sd_pkg::csr_type      csr;
   mbap_sd_pkg::in_item_type  item;
   mbap_sd_pkg::rsp_item_type result;
   mbap_sd_pkg::rsp_item_type rsp;
   logic                      advance;

   assign csr.write_en = csr_write_en;
   assign csr.index    = csr_index;
   assign csr.wdata    = csr_wdata;

   mbap_sd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .item        (item)
   );

   mbap_sd_parse #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   mbap_sd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .rsp_stall (rsp_stall),
      .advance   (advance),
      .rsp       (rsp)
   );

   assign req_stall     = item.valid && !advance;
   assign rsp_valid     = rsp.valid;
   assign rsp_pdu_byte  = rsp.pdu_byte;
   assign rsp_last_byte = rsp.last_byte;
   assign rsp_status    = rsp.status;
   assign rsp_frame_tid = rsp.frame_tid;

endmodule

@@ hw/rtl/mbap_sd_checker.sv @@
`include "mbap_stream_deframer_assert.svh"

module mbap_sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_pdu_byte,
   input logic        rsp_last_byte,
   input logic [2:0]  rsp_status,
   input logic [15:0] rsp_frame_tid
);

   `MBAP_SD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pdu_byte) && $stable(rsp_status) && $stable(rsp_frame_tid)), "stalled result item changed")
   `MBAP_SD_ASSERT(a_err_zero, clock, reset, (rsp_valid && rsp_status != 3'(mbap_sd_pkg::ST_DATA) |-> rsp_pdu_byte == 8'd0 && !rsp_last_byte), "error item carries data")
   `MBAP_SD_ASSERT(a_status_range, clock, reset, (rsp_valid |-> rsp_status <= 3'(mbap_sd_pkg::ST_TID)), "status code out of range")
   `MBAP_SD_ASSERT(a_last_data, clock, reset, (rsp_valid && rsp_last_byte |-> rsp_status == 3'(mbap_sd_pkg::ST_DATA)), "last byte flagged on an error item")
   `MBAP_SD_ASSERT_NR(a_reset_idle, clock, ($past(reset) |-> !rsp_valid), "result item shown straight after reset")

endmodule

bind mbap_stream_deframer mbap_sd_checker u_checker (.*);

@@ tb/mbap_stream_deframer_check.sv @@
`timescale 1ns / 1ps
module mbap_stream_deframer_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_pdu_byte,
   input  logic        rsp_last_byte,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_frame_tid,
   input  logic        csr_write_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          results_seen,
   output int          reports_seen
);

   typedef struct packed {
      logic [7:0]              pdu_byte;
      logic                    last_byte;
      mbap_sd_pkg::status_type status;
      logic [15:0]             frame_tid;
   } deframed_byte_type;

   deframed_byte_type awaited_bytes[$];

   logic [7:0]  hdr_bytes [0:mbap_sd_pkg::HDR_LEN-1];
   logic [8:0]  position;
   logic [15:0] frame_len;
   logic        skipping;
   logic [15:0] accepted_tid;
   logic        server_mode;
   logic [15:0] expected_tid;

   task automatic push_result(input logic [7:0] b, input logic fin,
                              input mbap_sd_pkg::status_type st);
      awaited_bytes.push_back('{pdu_byte: b, last_byte: fin, status: st,
                                frame_tid: {hdr_bytes[0], hdr_bytes[1]}});
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] len;
      logic [15:0] tid;
      mbap_sd_pkg::status_type verdict;
      int          idx;
      logic        fin;
      logic        drop;
      if (position < mbap_sd_pkg::HDR_LEN) begin
         hdr_bytes[position] = b;
         position = position + 9'd1;
         if (position == mbap_sd_pkg::HDR_LEN) begin
            len = {hdr_bytes[4], hdr_bytes[5]};
            tid = {hdr_bytes[0], hdr_bytes[1]};
            if (mbap_sd_pkg::HDR_LEN + int'(len) > mbap_sd_pkg::MAX_FRAME_DEF) begin
               // A length that cannot fit drops the header; the next byte opens a new one.
               position = '0;
               skipping = 1'b0;
               push_result(8'h00, 1'b0, mbap_sd_pkg::ST_RESYNC);
            end else begin
               frame_len = len;
               if (len < mbap_sd_pkg::MIN_LEN) begin
                  verdict = mbap_sd_pkg::ST_SHORT;
               end else if ({hdr_bytes[2], hdr_bytes[3]} != 16'h0000) begin
                  verdict = mbap_sd_pkg::ST_PROTO;
               end else if (!server_mode && tid != expected_tid) begin
                  verdict = mbap_sd_pkg::ST_TID;
               end else begin
                  verdict = mbap_sd_pkg::ST_DATA;
               end
               if (verdict != mbap_sd_pkg::ST_DATA) begin
                  // An empty body leaves nothing to swallow.
                  skipping = (len != 16'h0000);
                  if (len == 16'h0000) position = '0;
                  push_result(8'h00, 1'b0, verdict);
               end else begin
                  skipping = 1'b0;
                  accepted_tid = tid;
               end
            end
         end
      end else begin
         idx = int'(position) - mbap_sd_pkg::HDR_LEN;
         fin = (idx + 1 >= int'(frame_len));
         drop = skipping;
         if (fin) begin
            position = '0;
            skipping = 1'b0;
         end else begin
            position = position + 9'd1;
         end
         if (!drop) push_result(b, fin, mbap_sd_pkg::ST_DATA);
      end
   endtask

   task automatic check_result();
      deframed_byte_type want;
      if (awaited_bytes.size() == 0) begin
         $error("unexpected item: pdu_byte %0d last_byte %0d status %0d frame_tid %0d",
                rsp_pdu_byte, rsp_last_byte, rsp_status, rsp_frame_tid);
         fail_count++;
      end else begin
         want = awaited_bytes.pop_front();
         if (rsp_pdu_byte !== want.pdu_byte) begin
            $error("pdu_byte expected %0d actual %0d", want.pdu_byte, rsp_pdu_byte);
            fail_count++;
         end
         if (rsp_last_byte !== want.last_byte) begin
            $error("last_byte expected %0d actual %0d", want.last_byte, rsp_last_byte);
            fail_count++;
         end
         if (rsp_status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, rsp_status);
            fail_count++;
         end
         if (rsp_frame_tid !== want.frame_tid) begin
            $error("frame_tid expected %0d actual %0d", want.frame_tid, rsp_frame_tid);
            fail_count++;
         end
      end
      results_seen++;
      if (rsp_status != mbap_sd_pkg::ST_DATA) reports_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hdr_bytes    = '{default: '0};
         position     = '0;
         frame_len    = '0;
         skipping     = 1'b0;
         accepted_tid = '0;
         server_mode  = 1'b0;
         expected_tid = '0;
         awaited_bytes.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               mbap_sd_pkg::CSR_SERVER_MODE:  server_mode  = csr_wdata[0];
               mbap_sd_pkg::CSR_EXPECTED_TID: expected_tid = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) deframe_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) check_result();
      end
      pending = awaited_bytes.size();
   end

endmodule

@@ tb/mbap_stream_deframer_test.sv @@
`timescale 1ns / 1ps
module mbap_stream_deframer_test;

   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_BYTES = 300;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic [7:0]  req_rx_byte  = 8'h00;
   logic        rsp_stall    = 1'b0;
   logic        csr_write_en = 1'b0;
   logic        csr_index    = mbap_sd_pkg::CSR_SERVER_MODE;
   logic [15:0] csr_wdata    = 16'h0000;

   logic        req_stall;
   logic        rsp_valid;
   logic [7:0]  rsp_pdu_byte;
   logic        rsp_last_byte;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_frame_tid;

   int fail_count;
   int pending;
   int results_seen;
   int reports_seen;

   bit          calm     = 1'b0;
   bit          hold_req = 1'b0;
   logic        cfg_server = 1'b0;
   logic [15:0] cfg_tid    = 16'h0000;
   int          bytes_sent = 0;
   int          frames_sent = 0;
   int          settings_used = 1;

   mbap_stream_deframer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pdu_byte(rsp_pdu_byte),
      .rsp_last_byte(rsp_last_byte), .rsp_status(rsp_status), .rsp_frame_tid(rsp_frame_tid),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mbap_stream_deframer_check checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pdu_byte(rsp_pdu_byte),
      .rsp_last_byte(rsp_last_byte), .rsp_status(rsp_status), .rsp_frame_tid(rsp_frame_tid),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending),
      .results_seen(results_seen), .reports_seen(reports_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d results still awaited.", pending);
      $display("FAIL mbap_stream_deframer");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         rsp_stall <= (!calm && $urandom_range(99) < 20);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input logic [15:0] tid, input logic [15:0] proto,
                              input logic [15:0] len);
      send_byte(tid[15:8]);
      send_byte(tid[7:0]);
      send_byte(proto[15:8]);
      send_byte(proto[7:0]);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
      frames_sent++;
   endtask

   // A header, then as many body bytes as its length asks for if the frame fits.
   task automatic send_frame(input logic [15:0] tid, input logic [15:0] proto,
                             input logic [15:0] len);
      send_header(tid, proto, len);
      if (mbap_sd_pkg::HDR_LEN + int'(len) <= mbap_sd_pkg::MAX_FRAME_DEF) begin
         repeat (len) send_byte(8'($urandom));
      end
   endtask

   // Register writes wait until every result is out and the pipeline has drained.
   task automatic write_reg(input logic idx, input logic [15:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == mbap_sd_pkg::CSR_SERVER_MODE) cfg_server = val[0];
      else cfg_tid = val;
   endtask

   initial begin
      int          random_start;
      int          frame_no;
      int          pick;
      int          sel;
      logic [15:0] tid;
      logic [15:0] len;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: client mode, expected transaction id zero.
      // Too short wins over a bad protocol id and a wrong transaction id; empty body.
      send_header(16'hFFFF, 16'hFFFF, 16'h0000);
      send_frame(16'h0000, 16'h0001, 16'h0001);
      // Bad protocol id wins over a wrong transaction id.
      send_frame(16'h1234, 16'h8000, 16'h0002);
      send_frame(16'h1234, 16'h0000, 16'h0002);
      send_header(16'h0000, 16'h0000, 16'h0002);
      send_byte(8'hFF);
      send_byte(8'h00);
      // One past the largest frame, then the largest length field.
      send_header(16'h00FF, 16'h0000, 16'd255);
      send_header(16'hFF00, 16'h0000, 16'hFFFF);
      write_reg(mbap_sd_pkg::CSR_EXPECTED_TID, 16'hFFFF);
      send_frame(16'hFFFF, 16'h0000, 16'h0003);
      write_reg(mbap_sd_pkg::CSR_SERVER_MODE, 16'h0001);
      send_frame(16'h5A5A, 16'h0000, 16'h0002);

      // A frame sent while the receiver holds off, so the block backs up.
      hold_req = 1'b1;
      send_frame(16'($urandom), 16'h0000, 16'd24);
      settings_used = 3;

      random_start = bytes_sent;
      frame_no = 0;
      while (bytes_sent < random_start + RANDOM_BYTES) begin
         if (frame_no % 8 == 0) begin
            write_reg(mbap_sd_pkg::CSR_SERVER_MODE, {15'h0000, 1'($urandom_range(1))});
            sel = $urandom_range(3);
            write_reg(mbap_sd_pkg::CSR_EXPECTED_TID, (sel == 0) ? 16'h0000 :
                                                     (sel == 1) ? 16'hFFFF :
                                                     16'($urandom));
            settings_used++;
         end
         calm = (frame_no >= 16 && frame_no < 28);
         tid = cfg_server ? 16'($urandom) : cfg_tid;
         len = 16'($urandom_range(2, 12));
         if ($urandom_range(39) == 0) len = 16'($urandom_range(2, 254));
         pick = $urandom_range(99);
         if (pick < 4) begin
            // Stray bytes throw the framing out until a header lines up again.
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
         end else if (pick < 10) begin
            send_header(16'($urandom), 16'h0000, 16'($urandom_range(255, 65535)));
         end else if (pick < 16) begin
            send_frame(tid, ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom),
                       16'($urandom_range(1)));
         end else if (pick < 22) begin
            send_frame(tid, 16'($urandom_range(1, 65535)), len);
         end else if (pick < 30) begin
            send_frame(16'($urandom), 16'h0000, len);
         end else begin
            send_frame(tid, 16'h0000, len);
         end
         frame_no++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d stream bytes in %0d headers under %0d register settings.",
               bytes_sent, frames_sent, settings_used);
      $display("Checked %0d result items, %0d of them error reports.",
               results_seen, reports_seen);
      if (fail_count == 0) begin
         $display("PASS mbap_stream_deframer");
      end else begin
         $display("FAIL mbap_stream_deframer");
      end
      $finish;
   end

endmodule
